>>> design/lcar_pkg.sv
package lcar_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TARE_SUM_W = 32;
    localparam int TARE_REM_W = 8;
    localparam int PULSE_W    = 5;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 24;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 56;

    localparam logic [9:0] GRAMS_PER_KG = 10'd1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_SELECT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE       = 1'b1;

    localparam logic [1:0] GAIN_A128 = 2'd0;
    localparam logic [1:0] GAIN_A64  = 2'd1;
    localparam logic [1:0] GAIN_B32  = 2'd2;

    localparam logic [PULSE_W-1:0] PULSES_A128 = 5'd1;
    localparam logic [PULSE_W-1:0] PULSES_A64  = 5'd3;
    localparam logic [PULSE_W-1:0] PULSES_B32  = 5'd2;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_SHIFT,
        PH_GAIN
    } lcar_phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL,
        CS_WSTART,
        CS_WWAIT,
        CS_TSTART,
        CS_TWAIT
    } lcar_state_t;

    typedef struct packed {
        logic accept;
        logic shift_en;
        logic shift_clear;
        logic sck_level;
        logic sample_done;
        logic mul_en;
        logic div_start;
        logic div_sel_tare;
        logic out_load_sample;
        logic offset_load;
    } lcar_cmd_t;

    typedef struct packed {
        logic div_done;
        logic tare_finish;
    } lcar_status_t;

endpackage

>>> design/lcar_div.sv
module lcar_div
    import lcar_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, div_reg};
        fits      = !trial[DIVISOR_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/lcar_ctrl.sv
module lcar_ctrl
    import lcar_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   dout_level,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   s_tready,
    output lcar_cmd_t              cmd,
    input  lcar_status_t           status
);

    lcar_state_t          state_reg, state_next;
    lcar_phase_t          phase_reg, phase_next;
    logic                 clk_level_reg, clk_level_next;
    logic [PULSE_W-1:0]   pulse_cnt_reg, pulse_cnt_next;
    logic [1:0]           gain_reg, gain_next;
    logic [PULSE_W-1:0]   pulse_inc;
    logic [PULSE_W-1:0]   extra_pulses;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            phase_reg     <= PH_WAIT;
            clk_level_reg <= 1'b0;
            pulse_cnt_reg <= '0;
            gain_reg      <= GAIN_A128;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clk_level_reg <= clk_level_next;
            pulse_cnt_reg <= pulse_cnt_next;
            gain_reg      <= gain_next;
        end
    end

    always_comb begin
        gain_next = gain_reg;
        if (cfg_wr_en && cfg_index == CFG_GAIN_SELECT) begin
            gain_next = cfg_wr_data[1:0];
        end
        unique case (gain_reg)
            GAIN_A64: extra_pulses = PULSES_A64;
            GAIN_B32: extra_pulses = PULSES_B32;
            default:  extra_pulses = PULSES_A128;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clk_level_next = clk_level_reg;
        pulse_cnt_next = pulse_cnt_reg;
        pulse_inc      = pulse_cnt_reg + 1'b1;
        cmd            = '0;
        s_tready       = (state_reg == CS_IDLE) && (!m_tvalid || m_tready);
        cmd.accept     = s_tvalid && s_tready;

        unique case (state_reg)
            CS_IDLE: begin
                if (cmd.accept) begin
                    unique case (phase_reg)
                        PH_SHIFT, PH_GAIN: begin
                            if (!clk_level_reg) begin
                                cmd.sck_level  = 1'b1;
                                clk_level_next = 1'b1;
                                cmd.shift_en   = (phase_reg == PH_SHIFT);
                            end else begin
                                clk_level_next = 1'b0;
                                pulse_cnt_next = pulse_inc;
                                if (phase_reg == PH_SHIFT) begin
                                    if (pulse_inc >= PULSE_W'(SAMPLE_W)) begin
                                        phase_next     = PH_GAIN;
                                        pulse_cnt_next = '0;
                                    end
                                end else if (pulse_inc >= extra_pulses) begin
                                    phase_next      = PH_WAIT;
                                    pulse_cnt_next  = '0;
                                    cmd.sample_done = 1'b1;
                                    state_next      = CS_MUL;
                                end
                            end
                        end
                        default: begin
                            phase_next     = PH_WAIT;
                            clk_level_next = 1'b0;
                            if (!dout_level) begin
                                phase_next      = PH_SHIFT;
                                pulse_cnt_next  = '0;
                                cmd.shift_clear = 1'b1;
                            end
                        end
                    endcase
                end
            end
            CS_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = CS_WSTART;
            end
            CS_WSTART: begin
                cmd.div_start = 1'b1;
                state_next    = CS_WWAIT;
            end
            CS_WWAIT: begin
                if (status.div_done) begin
                    cmd.out_load_sample = 1'b1;
                    state_next = status.tare_finish ? CS_TSTART : CS_IDLE;
                end
            end
            CS_TSTART: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_tare = 1'b1;
                state_next       = CS_TWAIT;
            end
            CS_TWAIT: begin
                cmd.div_sel_tare = 1'b1;
                if (status.div_done) begin
                    cmd.offset_load = 1'b1;
                    state_next      = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> design/lcar_dp.sv
module lcar_dp
    import lcar_pkg::*;
#(
    parameter int unsigned TARE_COUNT = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   dout_level,
    input  logic                   tare_cmd,
    input  lcar_cmd_t              cmd,
    output lcar_status_t           status,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam logic [TARE_REM_W-1:0] TARE_LOAD = TARE_REM_W'(TARE_COUNT);

    logic [SAMPLE_W-1:0]   scale_reg, scale_next;
    logic [SAMPLE_W-1:0]   shift_reg, shift_next;
    logic [SAMPLE_W-1:0]   offset_reg, offset_next;
    logic [TARE_SUM_W-1:0] tare_sum_reg, tare_sum_next;
    logic [TARE_REM_W-1:0] tare_rem_reg, tare_rem_next;
    logic                  tare_finish_reg, tare_finish_next;
    logic                  busy_hold_reg, busy_hold_next;
    logic [SAMPLE_W-1:0]   raw_reg, raw_next;
    logic [DIFF_W-1:0]     diff_reg, diff_next;
    logic [DIVIDEND_W-1:0] prod_reg, prod_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_sck_reg, out_sck_next;
    logic                  out_sample_reg, out_sample_next;
    logic [SAMPLE_W-1:0]   out_raw_reg, out_raw_next;
    logic [SAMPLE_W-1:0]   out_weight_reg, out_weight_next;
    logic                  out_sat_reg, out_sat_next;
    logic                  out_busy_reg, out_busy_next;

    logic [TARE_SUM_W-1:0] sum_base;
    logic [TARE_REM_W-1:0] rem_base;
    logic [TARE_REM_W-1:0] rem_after;
    logic [TARE_SUM_W-1:0] sum_mag;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [SAMPLE_W-1:0]   quo_low;

    lcar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        sum_mag = tare_sum_reg[TARE_SUM_W-1] ? (TARE_SUM_W'(0) - tare_sum_reg) : tare_sum_reg;
        if (cmd.div_sel_tare) begin
            div_dividend = DIVIDEND_W'(sum_mag);
            div_divisor  = DIVISOR_W'(TARE_COUNT);
        end else begin
            div_dividend = prod_reg;
            div_divisor  = (scale_reg == '0) ? DIVISOR_W'(1) : scale_reg;
        end
        quo_low = div_quotient[SAMPLE_W-1:0];
    end

    always_comb begin
        scale_next       = scale_reg;
        shift_next       = shift_reg;
        offset_next      = offset_reg;
        tare_sum_next    = tare_sum_reg;
        tare_rem_next    = tare_rem_reg;
        tare_finish_next = tare_finish_reg;
        busy_hold_next   = busy_hold_reg;
        raw_next         = raw_reg;
        diff_next        = diff_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_sck_next     = out_sck_reg;
        out_sample_next  = out_sample_reg;
        out_raw_next     = out_raw_reg;
        out_weight_next  = out_weight_reg;
        out_sat_next     = out_sat_reg;
        out_busy_next    = out_busy_reg;

        sum_base  = tare_cmd ? '0 : tare_sum_reg;
        rem_base  = tare_cmd ? TARE_LOAD : tare_rem_reg;
        rem_after = (rem_base != '0) ? rem_base - 1'b1 : '0;

        if (cfg_wr_en && cfg_index == CFG_SCALE) begin
            scale_next = cfg_wr_data[SAMPLE_W-1:0];
        end

        if (cmd.shift_clear) begin
            shift_next = '0;
        end else if (cmd.shift_en) begin
            shift_next = {shift_reg[SAMPLE_W-2:0], dout_level};
        end

        if (cmd.accept) begin
            tare_sum_next = sum_base;
            tare_rem_next = rem_base;
            if (cmd.sample_done) begin
                raw_next  = shift_reg;
                diff_next = $signed({shift_reg[SAMPLE_W-1], shift_reg})
                          - $signed({offset_reg[SAMPLE_W-1], offset_reg});
                if (rem_base != '0) begin
                    tare_sum_next = sum_base
                                  + {{(TARE_SUM_W-SAMPLE_W){shift_reg[SAMPLE_W-1]}}, shift_reg};
                    tare_rem_next = rem_after;
                end
                tare_finish_next = (rem_base == TARE_REM_W'(1));
                busy_hold_next   = (rem_after != '0);
            end else begin
                out_valid_next  = 1'b1;
                out_sck_next    = cmd.sck_level;
                out_sample_next = 1'b0;
                out_raw_next    = '0;
                out_weight_next = '0;
                out_sat_next    = 1'b0;
                out_busy_next   = (rem_base != '0);
            end
        end

        if (cmd.mul_en) begin
            if (!diff_reg[DIFF_W-1] && diff_reg != '0) begin
                prod_next = DIVIDEND_W'(diff_reg[SAMPLE_W-1:0]) * DIVIDEND_W'(GRAMS_PER_KG);
            end else begin
                prod_next = '0;
            end
        end

        if (cmd.out_load_sample) begin
            out_valid_next  = 1'b1;
            out_sck_next    = 1'b0;
            out_sample_next = 1'b1;
            out_raw_next    = raw_reg;
            out_sat_next    = |div_quotient[DIVIDEND_W-1:SAMPLE_W];
            out_weight_next = out_sat_next ? '1 : quo_low;
            out_busy_next   = busy_hold_reg;
        end

        if (cmd.offset_load) begin
            offset_next = tare_sum_reg[TARE_SUM_W-1] ? (SAMPLE_W'(0) - quo_low) : quo_low;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= SAMPLE_W'(1);
            shift_reg       <= '0;
            offset_reg      <= '0;
            tare_sum_reg    <= '0;
            tare_rem_reg    <= '0;
            tare_finish_reg <= 1'b0;
            busy_hold_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            scale_reg       <= scale_next;
            shift_reg       <= shift_next;
            offset_reg      <= offset_next;
            tare_sum_reg    <= tare_sum_next;
            tare_rem_reg    <= tare_rem_next;
            tare_finish_reg <= tare_finish_next;
            busy_hold_reg   <= busy_hold_next;
            out_valid_reg   <= out_valid_next;
        end
        raw_reg        <= raw_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        out_sck_reg    <= out_sck_next;
        out_sample_reg <= out_sample_next;
        out_raw_reg    <= out_raw_next;
        out_weight_reg <= out_weight_next;
        out_sat_reg    <= out_sat_next;
        out_busy_reg   <= out_busy_next;
    end

    assign status.div_done    = div_done;
    assign status.tare_finish = tare_finish_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_busy_reg, out_sat_reg, out_weight_reg, out_raw_reg,
                       out_sample_reg, out_sck_reg};

endmodule

>>> design/load_cell_adc_reader_with_tare_core.sv
// A tick that completes no sample gives its result in the cycle after the transfer in,
// and the next tick may follow in the following cycle if m_tready is high then.
// A tick that completes a sample waits for the 34-step shared divider that forms the
// weight; a tick that also ends tare averaging then waits for the divide of the tare
// sum as well. No input is taken until that work is done.
// Reset (aresetn low, synchronous) returns the serial interface to waiting, clears tare
// state and offset, and sets gain 128 and a scale of one count per kilogram.
module load_cell_adc_reader_with_tare_core
    import lcar_pkg::*;
#(
    parameter int unsigned TARE_COUNT = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // dout_level
    input  logic                   s_tuser,   // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sck_level, sample_valid, raw_sample, weight_grams, weight_saturated, tare_busy
    output logic [M_TDATA_W-1:0]   m_tdata
);

    lcar_cmd_t    cmd;
    lcar_status_t status;

    lcar_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .dout_level  (s_tdata[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .s_tready    (s_tready),
        .cmd         (cmd),
        .status      (status)
    );

    lcar_dp #(
        .TARE_COUNT (TARE_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .dout_level  (s_tdata[0]),
        .tare_cmd    (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    a_blocked_output_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("Input taken while a result is stalled.");

    a_sample_finds_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load_sample |-> !m_tvalid)
        else $error("Sample result would overwrite a pending result.");

    a_sample_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && cmd.sample_done) |=> !s_tready)
        else $error("Input taken while the weight is being computed.");

    a_offset_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.offset_load |-> (status.div_done && cmd.div_sel_tare))
        else $error("Offset loaded without a finished tare divide.");

endmodule
